// ----- rtl/rcp_pkg.sv -----
package rcp_pkg;

    // Port field widths
    localparam int IN_W   = 24;
    localparam int EXT_W  = 23;

    // Internal widths, set by the Q16.8 field ranges
    localparam int D2_W   = 27;   // doubled center offset
    localparam int D_W    = 26;   // signed closest-point offset
    localparam int ABS_W  = 25;   // magnitude of the offset
    localparam int SQ_W   = 51;   // dx*dx + dy*dy
    localparam int ROOT_W = 26;   // integer square root
    localparam int PROD_W = 48;   // depth * |d|
    localparam int Q_W    = 23;   // quotient bits (quotient never reaches the radius)

    // Geometry that travels alongside the square root
    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic [EXT_W-1:0]      r;
    } geo_t;

    // Per-item flags that travel alongside the divider
    typedef struct packed {
        logic hit;
        logic pos_x;
        logic pos_y;
    } side_t;

endpackage

// ----- rtl/rcp_prep.sv -----
module rcp_prep (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [rcp_pkg::IN_W-1:0]  rect_x,
    input  logic signed [rcp_pkg::IN_W-1:0]  rect_y,
    input  logic [rcp_pkg::EXT_W-1:0]   rect_width,
    input  logic [rcp_pkg::EXT_W-1:0]   rect_height,
    input  logic signed [rcp_pkg::IN_W-1:0]  circle_x,
    input  logic signed [rcp_pkg::IN_W-1:0]  circle_y,
    input  logic [rcp_pkg::EXT_W-1:0]   circle_radius,
    output logic                        out_valid,
    output logic [rcp_pkg::SQ_W-1:0]    out_sum,
    output rcp_pkg::geo_t               out_geo
);
    import rcp_pkg::*;

    logic [3:0] v_reg;

    // Stage 1 registers
    logic signed [D2_W-1:0] d2x_reg, d2y_reg;
    logic [EXT_W-1:0]       w1_reg, h1_reg, r1_reg;
    // Stage 2 registers
    geo_t                   g2_reg;
    // Stage 3 registers
    geo_t                   g3_reg;
    logic [2*ABS_W-1:0]     sqx_reg, sqy_reg;
    // Stage 4 registers
    geo_t                   g4_reg;
    logic [SQ_W-1:0]        sum_reg;

    logic signed [D2_W-1:0] d2x_next, d2y_next;
    logic signed [D_W-1:0]  dx_next, dy_next;
    logic [ABS_W-1:0]       ax, ay;

    // Doubled offset from the rectangle center to the circle center
    function automatic logic signed [D2_W-1:0] diff2(
        input logic signed [IN_W-1:0] corner,
        input logic [EXT_W-1:0]       extent,
        input logic signed [IN_W-1:0] centre
    );
        logic signed [D2_W-1:0] c2;
        logic signed [D2_W-1:0] k2;
        c2 = {{2{centre[IN_W-1]}}, centre, 1'b0};
        k2 = {{2{corner[IN_W-1]}}, corner, 1'b0};
        return c2 - k2 - D2_W'(extent);
    endfunction

    // Clamp to the half-extent and turn back into a whole offset
    function automatic logic signed [D_W-1:0] offset(
        input logic signed [D2_W-1:0] d2,
        input logic [EXT_W-1:0]       extent
    );
        logic signed [D2_W-1:0] ext;
        logic signed [D2_W-1:0] cl;
        logic signed [D2_W-1:0] diff;
        ext = D2_W'(extent);
        if (d2 < -ext) begin
            cl = -ext;
        end else if (d2 > ext) begin
            cl = ext;
        end else begin
            cl = d2;
        end
        diff = cl - d2;
        return diff[D_W:1];
    endfunction

    function automatic logic [ABS_W-1:0] mag(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] n;
        n = d[D_W-1] ? -d : d;
        return n[ABS_W-1:0];
    endfunction

    assign d2x_next = diff2(rect_x, rect_width, circle_x);
    assign d2y_next = diff2(rect_y, rect_height, circle_y);
    assign dx_next  = offset(d2x_reg, w1_reg);
    assign dy_next  = offset(d2y_reg, h1_reg);
    assign ax       = mag(g2_reg.dx);
    assign ay       = mag(g2_reg.dy);

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            d2x_reg <= d2x_next;
            d2y_reg <= d2y_next;
            w1_reg  <= rect_width;
            h1_reg  <= rect_height;
            r1_reg  <= circle_radius;

            g2_reg.dx <= dx_next;
            g2_reg.dy <= dy_next;
            g2_reg.r  <= r1_reg;

            g3_reg  <= g2_reg;
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;

            g4_reg  <= g3_reg;
            sum_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
        end
    end

    assign out_valid = v_reg[3];
    assign out_sum   = sum_reg;
    assign out_geo   = g4_reg;

endmodule

// ----- rtl/rcp_sqrt.sv -----
module rcp_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rcp_pkg::SQ_W-1:0]    in_sum,
    input  rcp_pkg::geo_t               in_geo,
    output logic                        out_valid,
    output logic [rcp_pkg::ROOT_W-1:0]  out_root,
    output rcp_pkg::geo_t               out_geo
);
    import rcp_pkg::*;

    // One result bit per stage, remainder method
    logic [SQ_W-1:0] rem_reg  [ROOT_W];
    logic [SQ_W-1:0] root_reg [ROOT_W];
    geo_t            geo_reg  [ROOT_W];
    logic [ROOT_W-1:0] v_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [SQ_W-1:0] rem_src, root_src, trial;
        logic            v_src;
        geo_t            geo_src;

        if (k == 0) begin : g_first
            assign rem_src  = in_sum;
            assign root_src = '0;
            assign v_src    = in_valid;
            assign geo_src  = in_geo;
        end else begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign v_src    = v_reg[k-1];
            assign geo_src  = geo_reg[k-1];
        end

        assign trial = root_src + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_src;
            end
        end

        // Subtract the trial when it fits, then shift the root
        always_ff @(posedge aclk) begin
            if (en) begin
                geo_reg[k] <= geo_src;
                if (rem_src >= trial) begin
                    rem_reg[k]  <= rem_src - trial;
                    root_reg[k] <= (root_src >> 1) + BIT;
                end else begin
                    rem_reg[k]  <= rem_src;
                    root_reg[k] <= root_src >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_geo   = geo_reg[ROOT_W-1];

endmodule

// ----- rtl/rcp_div.sv -----
module rcp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [rcp_pkg::PROD_W-1:0]  in_num_x,
    input  logic [rcp_pkg::PROD_W-1:0]  in_num_y,
    input  logic [rcp_pkg::ROOT_W-1:0]  in_len,
    input  rcp_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [rcp_pkg::Q_W-1:0]     out_q_x,
    output logic [rcp_pkg::Q_W-1:0]     out_q_y,
    output rcp_pkg::side_t              out_side
);
    import rcp_pkg::*;

    localparam int DV_W = PROD_W + 1;

    // Restoring division, one quotient bit per stage, both axes side by side
    logic [PROD_W-1:0] rx_reg  [Q_W];
    logic [PROD_W-1:0] ry_reg  [Q_W];
    logic [Q_W-1:0]    qx_reg  [Q_W];
    logic [Q_W-1:0]    qy_reg  [Q_W];
    logic [ROOT_W-1:0] len_reg [Q_W];
    side_t             sd_reg  [Q_W];
    logic [Q_W-1:0]    v_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;
        logic [PROD_W-1:0] rx_src, ry_src;
        logic [Q_W-1:0]    qx_src, qy_src;
        logic [ROOT_W-1:0] len_src;
        side_t             sd_src;
        logic              v_src;
        logic [DV_W-1:0]   dv;
        logic              fit_x, fit_y;

        if (k == 0) begin : g_first
            assign rx_src  = in_num_x;
            assign ry_src  = in_num_y;
            assign qx_src  = '0;
            assign qy_src  = '0;
            assign len_src = in_len;
            assign sd_src  = in_side;
            assign v_src   = in_valid;
        end else begin : g_rest
            assign rx_src  = rx_reg[k-1];
            assign ry_src  = ry_reg[k-1];
            assign qx_src  = qx_reg[k-1];
            assign qy_src  = qy_reg[k-1];
            assign len_src = len_reg[k-1];
            assign sd_src  = sd_reg[k-1];
            assign v_src   = v_reg[k-1];
        end

        assign dv    = DV_W'(len_src) << SH;
        assign fit_x = DV_W'(rx_src) >= dv;
        assign fit_y = DV_W'(ry_src) >= dv;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[k] <= len_src;
                sd_reg[k]  <= sd_src;
                rx_reg[k]  <= fit_x ? PROD_W'(DV_W'(rx_src) - dv) : rx_src;
                ry_reg[k]  <= fit_y ? PROD_W'(DV_W'(ry_src) - dv) : ry_src;
                qx_reg[k]  <= {qx_src[Q_W-2:0], fit_x};
                qy_reg[k]  <= {qy_src[Q_W-2:0], fit_y};
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_q_x   = qx_reg[Q_W-1];
    assign out_q_y   = qy_reg[Q_W-1];
    assign out_side  = sd_reg[Q_W-1];

endmodule

// ----- rtl/rect_circle_penetration_core.sv -----
// Channel  Direction  Handshake          Word
// s_       in         s_valid / s_ready  rect_x, rect_y, rect_width, rect_height,
//                                        circle_x, circle_y, circle_radius
// m_       out        m_valid / m_ready  push_x, push_y, hit
//
// Takes one word per cycle unless the output word is held. Pipeline: 4 offset/square
// stages, 26 square-root stages (one root bit each), 2 depth/product stages and
// 23 divider stages (one quotient bit each), the last one the output register.
// Synchronous active-low reset empties the pipeline.
// When the output word is held, every stage freezes together and s_ready drops.
module rect_circle_penetration_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [rcp_pkg::IN_W-1:0]   s_rect_x,
    input  logic signed [rcp_pkg::IN_W-1:0]   s_rect_y,
    input  logic [rcp_pkg::EXT_W-1:0]         s_rect_width,
    input  logic [rcp_pkg::EXT_W-1:0]         s_rect_height,
    input  logic signed [rcp_pkg::IN_W-1:0]   s_circle_x,
    input  logic signed [rcp_pkg::IN_W-1:0]   s_circle_y,
    input  logic [rcp_pkg::EXT_W-1:0]         s_circle_radius,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rcp_pkg::IN_W-1:0]   m_push_x,
    output logic signed [rcp_pkg::IN_W-1:0]   m_push_y,
    output logic                              m_hit
);
    import rcp_pkg::*;

    logic              en;
    logic              pv, sv;
    logic [SQ_W-1:0]   sum;
    geo_t              pgeo, sgeo;
    logic [ROOT_W-1:0] root;

    logic [1:0]        v_reg;
    logic [ROOT_W-1:0] len1_reg, len2_reg;
    logic [EXT_W-1:0]  depth_reg;
    logic [ABS_W-1:0]  ax_reg, ay_reg;
    side_t             sd1_reg, sd2_reg;
    logic [PROD_W-1:0] nx_reg, ny_reg;

    logic              dv;
    logic [Q_W-1:0]    qx, qy;
    side_t             dsd;
    logic              hit_next;
    logic [ROOT_W-1:0] r_ext;

    // Freeze the whole pipe while the output word waits
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rcp_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .rect_x        (s_rect_x),
        .rect_y        (s_rect_y),
        .rect_width    (s_rect_width),
        .rect_height   (s_rect_height),
        .circle_x      (s_circle_x),
        .circle_y      (s_circle_y),
        .circle_radius (s_circle_radius),
        .out_valid     (pv),
        .out_sum       (sum),
        .out_geo       (pgeo)
    );

    rcp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pv),
        .in_sum    (sum),
        .in_geo    (pgeo),
        .out_valid (sv),
        .out_root  (root),
        .out_geo   (sgeo)
    );

    // Hit test and penetration depth
    assign r_ext    = ROOT_W'(sgeo.r);
    assign hit_next = (root != '0) && (root < r_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], sv};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len1_reg      <= root;
            depth_reg     <= sgeo.r - root[EXT_W-1:0];
            ax_reg        <= sgeo.dx[D_W-1] ? ABS_W'(-sgeo.dx) : ABS_W'(sgeo.dx);
            ay_reg        <= sgeo.dy[D_W-1] ? ABS_W'(-sgeo.dy) : ABS_W'(sgeo.dy);
            sd1_reg.hit   <= hit_next;
            sd1_reg.pos_x <= !sgeo.dx[D_W-1];
            sd1_reg.pos_y <= !sgeo.dy[D_W-1];

            // Scale each axis by the depth
            len2_reg <= len1_reg;
            sd2_reg  <= sd1_reg;
            nx_reg   <= depth_reg * ax_reg;
            ny_reg   <= depth_reg * ay_reg;
        end
    end

    rcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[1]),
        .in_num_x  (nx_reg),
        .in_num_y  (ny_reg),
        .in_len    (len2_reg),
        .in_side   (sd2_reg),
        .out_valid (dv),
        .out_q_x   (qx),
        .out_q_y   (qy),
        .out_side  (dsd)
    );

    // Point the push away from the closest point; drop it on a miss
    assign m_valid  = dv;
    assign m_hit    = dsd.hit;
    assign m_push_x = !dsd.hit ? '0 : (dsd.pos_x ? -IN_W'(qx) : IN_W'(qx));
    assign m_push_y = !dsd.hit ? '0 : (dsd.pos_y ? -IN_W'(qy) : IN_W'(qy));

endmodule

// ----- rtl/rcp_checker.sv -----
module rcp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [rcp_pkg::IN_W-1:0]   m_push_x,
    input logic signed [rcp_pkg::IN_W-1:0]   m_push_y,
    input logic                              m_hit
);
    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    // An empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A miss carries no push
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_push_x == '0 && m_push_y == '0)
        else $error("push on a miss");

    // A held output word keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_push_x) && $stable(m_push_y)
            && $stable(m_hit))
        else $error("output word changed while stalled");

endmodule

bind rect_circle_penetration_core rcp_checker u_rcp_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Holds the predicted push vectors in order and checks each output word.
class penetration_scoreboard;
    typedef struct packed {
        logic signed [23:0] push_x;
        logic signed [23:0] push_y;
        logic               hit;
    } push_word_t;

    push_word_t pending_q[$];
    int         errors;

    function longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Closest-point offset along one axis at doubled scale, then halved exactly.
    function longint closest_offset(longint corner, longint extent, longint ctr);
        longint diff2;
        longint cl;
        diff2 = 2 * ctr - (2 * corner + extent);
        cl = diff2;
        if (cl < -extent) cl = -extent;
        if (cl > extent) cl = extent;
        return (cl - diff2) / 2;
    endfunction

    function longint push_axis(longint d, longint depth, longint len);
        longint mag;
        if (d == 0) return 0;
        mag = (depth * (d < 0 ? -d : d)) / len;
        mag = d > 0 ? -mag : mag;
        if (mag > 8388607) mag = 8388607;
        if (mag < -8388608) mag = -8388608;
        return mag;
    endfunction

    function void note_query(logic signed [23:0] rx, logic signed [23:0] ry,
                             logic [22:0] w, logic [22:0] h,
                             logic signed [23:0] cx, logic signed [23:0] cy,
                             logic [22:0] r);
        longint     dx;
        longint     dy;
        longint     len;
        push_word_t e;
        dx = closest_offset(rx, w, cx);
        dy = closest_offset(ry, h, cy);
        len = isqrt(dx * dx + dy * dy);
        e = '0;
        if (len > 0 && len < longint'(r)) begin
            e.push_x = 24'(push_axis(dx, longint'(r) - len, len));
            e.push_y = 24'(push_axis(dy, longint'(r) - len, len));
            e.hit = 1'b1;
        end
        pending_q.push_back(e);
    endfunction

    function void check_word(logic signed [23:0] px, logic signed [23:0] py, logic hit);
        push_word_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected word px=%0d py=%0d hit=%0b", $time, px, py, hit);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (px !== e.push_x) begin
            $display("%0t: push_x expected %0d actual %0d", $time, e.push_x, px);
            errors++;
        end
        if (py !== e.push_y) begin
            $display("%0t: push_y expected %0d actual %0d", $time, e.push_y, py);
            errors++;
        end
        if (hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
            errors++;
        end
    endfunction
endclass

module tb;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [23:0] s_rect_x;
    logic signed [23:0] s_rect_y;
    logic [22:0]        s_rect_width;
    logic [22:0]        s_rect_height;
    logic signed [23:0] s_circle_x;
    logic signed [23:0] s_circle_y;
    logic [22:0]        s_circle_radius;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_push_x;
    logic signed [23:0] m_push_y;
    logic               m_hit;

    penetration_scoreboard sb;
    int  src_idle_pct;
    int  sink_stall_pct;
    int  quiet_cycles = 0;
    bit  timed_out = 1'b0;

    rect_circle_penetration_core i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check output words and pace the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_push_x, m_push_y, m_hit);
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) timed_out <= 1'b1;
        end
    end

    // Hold valid low while idling, then present the word until it is taken.
    task automatic send_query(logic signed [23:0] rx, logic signed [23:0] ry,
                              logic [22:0] w, logic [22:0] h,
                              logic signed [23:0] cx, logic signed [23:0] cy,
                              logic [22:0] r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_rect_x        <= rx;
        s_rect_y        <= ry;
        s_rect_width    <= w;
        s_rect_height   <= h;
        s_circle_x      <= cx;
        s_circle_y      <= cy;
        s_circle_radius <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_query(rx, ry, w, h, cx, cy, r);
    endtask

    // Random pair: mostly near-contact geometry at varied scale, some full-range.
    task automatic send_random_query();
        logic signed [23:0] rx;
        logic signed [23:0] ry;
        logic [22:0]        w;
        logic [22:0]        h;
        logic [22:0]        r;
        int                 span;
        if ($urandom_range(3) == 0) begin
            send_query(24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
                       24'($urandom), 24'($urandom), 23'($urandom));
        end else begin
            span = 1 << $urandom_range(4, 22);
            rx = 24'($signed(24'($urandom_range(span))) - span / 2);
            ry = 24'($signed(24'($urandom_range(span))) - span / 2);
            w  = 23'($urandom_range(span / 2));
            h  = 23'($urandom_range(span / 2));
            r  = 23'($urandom_range(span / 2));
            send_query(rx, ry, w, h,
                       24'(rx + $signed(24'($urandom_range(w + 2 * r))) - r),
                       24'(ry + $signed(24'($urandom_range(h + 2 * r))) - r), r);
        end
    endtask

    initial begin
        sb = new();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rect_x = '0;
        s_rect_y = '0;
        s_rect_width = '0;
        s_rect_height = '0;
        s_circle_x = '0;
        s_circle_y = '0;
        s_circle_radius = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: center inside, each side, corners, extremes, touching edges.
        send_query(0, 0, 2560, 2560, 1280, 1280, 1000);
        send_query(0, 0, 2560, 2560, -200, 1280, 512);
        send_query(0, 0, 2560, 2560, 2760, 1280, 512);
        send_query(0, 0, 2560, 2560, 1280, -200, 512);
        send_query(0, 0, 2560, 2560, 1280, 2760, 512);
        send_query(0, 0, 2560, 2560, -300, -400, 600);
        send_query(0, 0, 2560, 2560, 2860, 2960, 600);
        send_query(0, 0, 2560, 2560, -300, -400, 500);
        send_query(0, 0, 2560, 2560, -1, 1280, 1);
        send_query(0, 0, 2560, 2560, -1, 1280, 2);
        send_query(0, 0, 0, 0, 5, 0, 23'h7FFFFF);
        send_query(0, 0, 0, 0, 0, 0, 23'h7FFFFF);
        send_query(24'sh800000, 24'sh800000, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
        send_query(24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 24'sh800000, 24'sh800000, 23'h7FFFFF);
        send_query(24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF,
                   24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
        send_query(24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF,
                   24'sh800000, 24'sh7FFFFF, 23'h7FFFFF);
        send_query(100, 100, 1, 1, 90, 101, 0);
        send_query(100, 100, 1, 1, 90, 101, 23'h7FFFFF);
        send_query(24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 0, 0, 23'h7FFFFF);

        // Random phases over the idling mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin src_idle_pct = 61; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 61; end
                3: begin src_idle_pct = 28; sink_stall_pct = 28; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            for (int i = 0; i < 100 && !timed_out; i++) send_random_query();
        end
        s_valid <= 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        // Drain, then allow the pipeline depth.
        while (sb.pending_q.size() != 0 && !timed_out) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (!timed_out && sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS rect_circle_penetration_core");
        end else begin
            $display("FAIL rect_circle_penetration_core");
        end
        $finish;
    end

    // Stop a stuck run.
    always @(posedge aclk) begin
        if (timed_out) begin
            $display("%0t: no handshake for too long", $time);
            $display("FAIL rect_circle_penetration_core");
            $finish;
        end
    end
endmodule
